// ----- sv/brc_pkg.sv -----
// ----------------------------------------------------------------------------
// brc_pkg: shared types and constants for barometer reading compensation
// Register indexes, fixed arithmetic constants and the side-band record
// that rides along the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package brc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP_WORDS    = 2'd0,
        CFG_PRESS_WORDS_A = 2'd1,
        CFG_PRESS_WORDS_B = 2'd2,
        CFG_PRESS_NINE    = 2'd3
    } cfg_index_t;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 31;
    localparam int DIV_STEPS  = DIVIDEND_W;

    localparam int CENTI_W = 18;

    localparam logic [22:0] FINE_OFFSET  = 23'd128000;
    localparam logic [20:0] PRESS_BASE   = 21'd1048576;
    localparam logic [63:0] DIV_SCALE    = 64'd3125;
    localparam logic [25:0] CENTI_ROUND  = 26'd128;
    localparam logic [55:0] LINEAR_BIAS  = 56'd140737488355328;   // 2^47

    // Fields that travel beside the quotient
    typedef struct packed {
        logic signed [CENTI_W-1:0] centi;
        logic                      neg;
        logic                      zero;
    } brc_side_t;

endpackage

`default_nettype wire

// ----- sv/barometer_reading_compensation.sv -----
// ----------------------------------------------------------------------------
// barometer_reading_compensation: integer temperature/pressure compensation
// Pipeline of 10 front stages, a 64-stage divider (one quotient bit
// per stage) and 5 back stages. Throughput one item per cycle; the whole
// pipe holds while the output register is valid and stalled. Reset clears
// all valid bits and sets the calibration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module barometer_reading_compensation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [19:0] raw_temperature,
    input  wire logic [19:0] raw_pressure,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] temperature_centi,
    output logic [31:0]      pressure_q24_8,
    output logic             pressure_invalid
);

    localparam int CW = brc_pkg::CENTI_W;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg;
    logic [63:0] cal_press_b_reg;
    logic [15:0] cal_nine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_nine_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (brc_pkg::cfg_index_t'(cfg_index))
                brc_pkg::CFG_TEMP_WORDS:    cal_temp_reg    <= cfg_data[47:0];
                brc_pkg::CFG_PRESS_WORDS_A: cal_press_a_reg <= cfg_data;
                brc_pkg::CFG_PRESS_WORDS_B: cal_press_b_reg <= cfg_data;
                brc_pkg::CFG_PRESS_NINE:    cal_nine_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Coefficient slices. Calibration must only change while the pipe is empty;
    // the block does not enforce it. Every stage reads the live registers.
    logic        [15:0] t1;
    logic signed [15:0] t2, t3;
    logic        [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_temp_reg[15:0];
    assign t2 = $signed(cal_temp_reg[31:16]);
    assign t3 = $signed(cal_temp_reg[47:32]);
    assign p1 = cal_press_a_reg[15:0];
    assign p2 = $signed(cal_press_a_reg[31:16]);
    assign p3 = $signed(cal_press_a_reg[47:32]);
    assign p4 = $signed(cal_press_a_reg[63:48]);
    assign p5 = $signed(cal_press_b_reg[15:0]);
    assign p6 = $signed(cal_press_b_reg[31:16]);
    assign p7 = $signed(cal_press_b_reg[47:32]);
    assign p8 = $signed(cal_press_b_reg[63:48]);
    assign p9 = $signed(cal_nine_reg);

    // ------------------------------------------------------------------
    // Flow control: one global advance. The pipe only holds when the
    // output register carries a result that the sink refuses.
    // ------------------------------------------------------------------
    logic adv;
    logic s15_vld_reg;

    assign adv      = !(s15_vld_reg && out_stall);
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // S1: temperature products (32-bit wrap kept in the low bits)
    // ------------------------------------------------------------------
    logic               s1_vld_reg;
    logic        [31:0] s1_ua_reg, s1_dd_reg;
    logic        [20:0] s1_pr_reg;

    logic signed [17:0] u_s;
    logic signed [16:0] d_s;
    logic signed [33:0] ua_full;
    logic signed [33:0] dd_full;

    assign u_s     = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign d_s     = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign ua_full = 34'(u_s) * 34'(t2);
    assign dd_full = 34'(d_s) * 34'(d_s);

    // ------------------------------------------------------------------
    // S2: a term, scaled d^2 times T3
    // ------------------------------------------------------------------
    logic               s2_vld_reg;
    logic signed [20:0] s2_a_reg;
    logic        [31:0] s2_b1_reg;
    logic        [20:0] s2_pr_reg;
    logic signed [35:0] b1_full;

    assign b1_full = 36'($signed(s1_dd_reg[31:12])) * 36'(t3);

    // ------------------------------------------------------------------
    // S3: fine temperature (fits 22 bits, no wrap possible)
    // ------------------------------------------------------------------
    logic               s3_vld_reg;
    logic signed [21:0] s3_fine_reg;
    logic        [20:0] s3_pr_reg;
    logic signed [21:0] fine_next;

    assign fine_next = 22'(s2_a_reg) + 22'($signed(s2_b1_reg[31:14]));

    // ------------------------------------------------------------------
    // S4: centidegrees and pressure offset term x = fine - 128000
    // ------------------------------------------------------------------
    logic                 s4_vld_reg;
    logic signed [CW-1:0] s4_centi_reg;
    logic signed [22:0]   s4_x_reg;
    logic        [20:0]   s4_pr_reg;
    logic signed [25:0]   centi_full;

    assign centi_full = 26'(s3_fine_reg) * 26'sd5 + $signed(brc_pkg::CENTI_ROUND);

    // ------------------------------------------------------------------
    // S5: x^2, x*P5, x*P2
    // ------------------------------------------------------------------
    logic                 s5_vld_reg;
    logic signed [45:0]   s5_xx_reg;
    logic signed [38:0]   s5_xp5_reg, s5_xp2_reg;
    logic        [20:0]   s5_pr_reg;
    logic signed [CW-1:0] s5_centi_reg;

    // ------------------------------------------------------------------
    // S6: x^2*P6, x^2*P3
    // ------------------------------------------------------------------
    logic                 s6_vld_reg;
    logic signed [61:0]   s6_ya_reg, s6_xx3_reg;
    logic signed [38:0]   s6_xp5_reg, s6_xp2_reg;
    logic        [20:0]   s6_pr_reg;
    logic signed [CW-1:0] s6_centi_reg;

    // ------------------------------------------------------------------
    // S7: y sum and x2 sum
    // ------------------------------------------------------------------
    logic                 s7_vld_reg;
    logic        [63:0]   s7_y_reg;
    logic        [54:0]   s7_x2_reg;
    logic        [20:0]   s7_pr_reg;
    logic signed [CW-1:0] s7_centi_reg;
    logic        [63:0]   y_next;
    logic        [54:0]   x2_next;

    assign y_next  = {{2{s6_ya_reg[61]}}, s6_ya_reg}
                   + {{8{s6_xp5_reg[38]}}, s6_xp5_reg, 17'b0}
                   + {{13{p4[15]}}, p4, 35'b0};
    assign x2_next = {s6_xx3_reg[61], s6_xx3_reg[61:8]}
                   + {{4{s6_xp2_reg[38]}}, s6_xp2_reg, 12'b0};

    // ------------------------------------------------------------------
    // S8: divisor (2^47 + x2)*P1 >> 33, numerator difference
    // ------------------------------------------------------------------
    logic                 s8_vld_reg;
    logic        [30:0]   s8_den_reg;
    logic        [63:0]   s8_diff_reg;
    logic signed [CW-1:0] s8_centi_reg;
    logic signed [55:0]   lin_base;
    logic signed [72:0]   x3p_full;

    assign lin_base = $signed({s7_x2_reg[54], s7_x2_reg}) + $signed(brc_pkg::LINEAR_BIAS);
    assign x3p_full = 73'(lin_base) * 73'($signed({1'b0, p1}));

    // ------------------------------------------------------------------
    // S9: numerator times 3125
    // ------------------------------------------------------------------
    logic                 s9_vld_reg;
    logic        [30:0]   s9_den_reg;
    logic        [63:0]   s9_num_reg;
    logic signed [CW-1:0] s9_centi_reg;

    // ------------------------------------------------------------------
    // S10: magnitudes and quotient sign for the divider
    // ------------------------------------------------------------------
    logic                 s10_vld_reg;
    logic        [63:0]   s10_an_reg;
    logic        [30:0]   s10_ad_reg;
    brc_pkg::brc_side_t   s10_side_reg;

    // ------------------------------------------------------------------
    // Divider pipeline
    // ------------------------------------------------------------------
    logic                 dv_vld;
    logic        [63:0]   dv_quot;
    brc_pkg::brc_side_t   dv_side;

    brc_sdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s10_vld_reg),
        .dividend (s10_an_reg),
        .divisor  (s10_ad_reg),
        .side_in  (s10_side_reg),
        .out_vld  (dv_vld),
        .quotient (dv_quot),
        .side_out (dv_side)
    );

    // ------------------------------------------------------------------
    // S11: signed quotient p (the -2^63 / -1 case wraps by itself)
    // ------------------------------------------------------------------
    logic                 s11_vld_reg;
    logic        [63:0]   s11_p_reg;
    logic                 s11_zero_reg;
    logic signed [CW-1:0] s11_centi_reg;

    // ------------------------------------------------------------------
    // S12: P9*s and P8*p, low 64 bits
    // ------------------------------------------------------------------
    logic                 s12_vld_reg;
    logic        [63:0]   s12_p_reg, s12_p9s_reg, s12_yp_reg;
    logic                 s12_zero_reg;
    logic signed [CW-1:0] s12_centi_reg;
    logic signed [66:0]   p9s_full;
    logic signed [79:0]   yp_full;

    assign p9s_full = 67'(p9) * 67'($signed(s11_p_reg[63:13]));
    assign yp_full  = 80'(p8) * 80'($signed(s11_p_reg));

    // ------------------------------------------------------------------
    // S13: (P9*s)*s low 64 bits as three 32x32 partial products
    // ------------------------------------------------------------------
    logic                 s13_vld_reg;
    logic        [63:0]   s13_ll_reg;
    logic        [31:0]   s13_c1_reg, s13_c2_reg;
    logic        [63:0]   s13_p_reg, s13_yp_reg;
    logic                 s13_zero_reg;
    logic signed [CW-1:0] s13_centi_reg;
    logic        [63:0]   s_ext;
    logic        [63:0]   ll_full, c1_full, c2_full;

    assign s_ext   = {{13{s12_p_reg[63]}}, s12_p_reg[63:13]};
    assign ll_full = 64'(s12_p9s_reg[31:0]) * 64'(s_ext[31:0]);
    assign c1_full = 64'(s12_p9s_reg[31:0]) * 64'(s_ext[63:32]);
    assign c2_full = 64'(s12_p9s_reg[63:32]) * 64'(s_ext[31:0]);

    // ------------------------------------------------------------------
    // S14: combine partial products
    // ------------------------------------------------------------------
    logic                 s14_vld_reg;
    logic        [63:0]   s14_xs_reg, s14_p_reg, s14_yp_reg;
    logic                 s14_zero_reg;
    logic signed [CW-1:0] s14_centi_reg;
    logic        [31:0]   cross_sum;

    assign cross_sum = s13_c1_reg + s13_c2_reg;

    // ------------------------------------------------------------------
    // S15: final sum, output register
    // ------------------------------------------------------------------
    logic signed [31:0]   s15_centi_reg;
    logic        [31:0]   s15_press_reg;
    logic                 s15_inv_reg;
    logic        [63:0]   fin_sum;
    logic        [31:0]   press_next;

    assign fin_sum    = s14_p_reg
                      + {{25{s14_xs_reg[63]}}, s14_xs_reg[63:25]}
                      + {{19{s14_yp_reg[63]}}, s14_yp_reg[63:19]};
    assign press_next = fin_sum[39:8] + {{12{p7[15]}}, p7, 4'b0};

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= dv_vld;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= s13_vld_reg;
            s15_vld_reg <= s14_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // S1
            s1_ua_reg <= ua_full[31:0];
            s1_dd_reg <= dd_full[31:0];
            s1_pr_reg <= brc_pkg::PRESS_BASE - {1'b0, raw_pressure};
            // S2
            s2_a_reg  <= $signed(s1_ua_reg[31:11]);
            s2_b1_reg <= b1_full[31:0];
            s2_pr_reg <= s1_pr_reg;
            // S3
            s3_fine_reg <= fine_next;
            s3_pr_reg   <= s2_pr_reg;
            // S4
            s4_centi_reg <= centi_full[25:8];
            s4_x_reg     <= 23'(s3_fine_reg) - $signed(brc_pkg::FINE_OFFSET);
            s4_pr_reg    <= s3_pr_reg;
            // S5
            s5_xx_reg    <= 46'(s4_x_reg) * 46'(s4_x_reg);
            s5_xp5_reg   <= 39'(s4_x_reg) * 39'(p5);
            s5_xp2_reg   <= 39'(s4_x_reg) * 39'(p2);
            s5_pr_reg    <= s4_pr_reg;
            s5_centi_reg <= s4_centi_reg;
            // S6
            s6_ya_reg    <= 62'(s5_xx_reg) * 62'(p6);
            s6_xx3_reg   <= 62'(s5_xx_reg) * 62'(p3);
            s6_xp5_reg   <= s5_xp5_reg;
            s6_xp2_reg   <= s5_xp2_reg;
            s6_pr_reg    <= s5_pr_reg;
            s6_centi_reg <= s5_centi_reg;
            // S7
            s7_y_reg     <= y_next;
            s7_x2_reg    <= x2_next;
            s7_pr_reg    <= s6_pr_reg;
            s7_centi_reg <= s6_centi_reg;
            // S8
            s8_den_reg   <= x3p_full[63:33];
            s8_diff_reg  <= {12'b0, s7_pr_reg, 31'b0} - s7_y_reg;
            s8_centi_reg <= s7_centi_reg;
            // S9
            s9_num_reg   <= s8_diff_reg * brc_pkg::DIV_SCALE;
            s9_den_reg   <= s8_den_reg;
            s9_centi_reg <= s8_centi_reg;
            // S10
            s10_an_reg         <= s9_num_reg[63] ? (64'd0 - s9_num_reg) : s9_num_reg;
            s10_ad_reg         <= s9_den_reg[30] ? (31'd0 - s9_den_reg) : s9_den_reg;
            s10_side_reg.centi <= s9_centi_reg;
            s10_side_reg.neg   <= s9_num_reg[63] ^ s9_den_reg[30];
            s10_side_reg.zero  <= (s9_den_reg == '0);
            // S11
            s11_p_reg     <= dv_side.neg ? (64'd0 - dv_quot) : dv_quot;
            s11_zero_reg  <= dv_side.zero;
            s11_centi_reg <= dv_side.centi;
            // S12
            s12_p_reg     <= s11_p_reg;
            s12_p9s_reg   <= p9s_full[63:0];
            s12_yp_reg    <= yp_full[63:0];
            s12_zero_reg  <= s11_zero_reg;
            s12_centi_reg <= s11_centi_reg;
            // S13
            s13_ll_reg    <= ll_full;
            s13_c1_reg    <= c1_full[31:0];
            s13_c2_reg    <= c2_full[31:0];
            s13_p_reg     <= s12_p_reg;
            s13_yp_reg    <= s12_yp_reg;
            s13_zero_reg  <= s12_zero_reg;
            s13_centi_reg <= s12_centi_reg;
            // S14
            s14_xs_reg    <= s13_ll_reg + {cross_sum, 32'b0};
            s14_p_reg     <= s13_p_reg;
            s14_yp_reg    <= s13_yp_reg;
            s14_zero_reg  <= s13_zero_reg;
            s14_centi_reg <= s13_centi_reg;
            // S15: zero divisor forces pressure to 0 and flags it
            s15_centi_reg <= 32'(s14_centi_reg);
            s15_press_reg <= s14_zero_reg ? 32'd0 : press_next;
            s15_inv_reg   <= s14_zero_reg;
        end
    end

    assign out_valid         = s15_vld_reg;
    assign temperature_centi = s15_centi_reg;
    assign pressure_q24_8    = s15_press_reg;
    assign pressure_invalid  = s15_inv_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s15_vld_reg && s15_inv_reg) |-> (s15_press_reg == '0))
        else $error("invalid result carries nonzero pressure");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s10_vld_reg && s10_side_reg.zero) |-> (s10_ad_reg == '0))
        else $error("zero flag without zero divisor");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_vld_reg)
        else $error("accepted transfer lost at entry");

endmodule

`default_nettype wire

// ----- sv/brc_sdiv.sv -----
// ----------------------------------------------------------------------------
// brc_sdiv: pipelined unsigned restoring divider
// One quotient bit per stage; a stage enable freezes the whole pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_sdiv (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_vld,
    input  wire logic [brc_pkg::DIVIDEND_W-1:0]   dividend,
    input  wire logic [brc_pkg::DIVISOR_W-1:0]    divisor,
    input  wire brc_pkg::brc_side_t               side_in,
    output logic                                  out_vld,
    output logic [brc_pkg::DIVIDEND_W-1:0]        quotient,
    output brc_pkg::brc_side_t                    side_out
);

    localparam int N  = brc_pkg::DIV_STEPS;
    localparam int DW = brc_pkg::DIVIDEND_W;
    localparam int RW = brc_pkg::DIVISOR_W;

    logic                vld_reg  [N];
    logic [RW-1:0]       rem_reg  [N];
    logic [DW-1:0]       dq_reg   [N];
    logic [RW-1:0]       dvs_reg  [N];
    brc_pkg::brc_side_t  side_reg [N];

    logic [RW-1:0]       rem_src  [N];
    logic [DW-1:0]       dq_src   [N];
    logic [RW-1:0]       dvs_src  [N];
    brc_pkg::brc_side_t  side_src [N];
    logic                vld_src  [N];

    logic [RW:0]         trial    [N];
    logic [RW-1:0]       rem_next [N];
    logic [DW-1:0]       dq_next  [N];

    // dq holds the unconsumed dividend bits on top, quotient bits shift in below
    always_comb
    begin
        rem_src[0]  = '0;
        dq_src[0]   = dividend;
        dvs_src[0]  = divisor;
        side_src[0] = side_in;
        vld_src[0]  = in_vld;
        for (int i = 1; i < N; i++)
        begin
            rem_src[i]  = rem_reg[i-1];
            dq_src[i]   = dq_reg[i-1];
            dvs_src[i]  = dvs_reg[i-1];
            side_src[i] = side_reg[i-1];
            vld_src[i]  = vld_reg[i-1];
        end
        for (int i = 0; i < N; i++)
        begin
            trial[i] = {rem_src[i], dq_src[i][DW-1]};
            if (trial[i] >= {1'b0, dvs_src[i]})
            begin
                rem_next[i] = RW'(trial[i] - {1'b0, dvs_src[i]});
                dq_next[i]  = {dq_src[i][DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][RW-1:0];
                dq_next[i]  = {dq_src[i][DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                vld_reg[i] <= vld_src[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                dq_reg[i]   <= dq_next[i];
                dvs_reg[i]  <= dvs_src[i];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign quotient = dq_reg[N-1];
    assign side_out = side_reg[N-1];

    // remainder stays below a nonzero divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[N-1] && (dvs_reg[N-1] != '0)) |-> (rem_reg[N-1] < dvs_reg[N-1]))
        else $error("divider remainder out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[N-1]))
        else $error("divider moved while held");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (en && in_vld) |=> vld_reg[0])
        else $error("divider lost an entering item");

endmodule

`default_nettype wire
